[src/two_channel_lamp_dimmer_top_macros.svh]
`ifndef TWO_CHANNEL_LAMP_DIMMER_TOP_MACROS_SVH
`define TWO_CHANNEL_LAMP_DIMMER_TOP_MACROS_SVH

// Clocked check, off while reset is asserted.
`define TCLD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen at a clock edge.
`define TCLD_NEVER(label, cond, msg) \
	`TCLD_ASSERT(label, !(cond), msg)

`endif

[src/tcld_pkg.sv]
package tcld_pkg;

	// Reciprocal of the fade divisor, scaled by 2**RECIP_SHIFT and rounded up.
	localparam int unsigned RECIP_SHIFT = 17;
	localparam int unsigned RECIP_W     = 18;
	localparam int unsigned RECIP_CNT_W = 5;

	localparam logic [7:0]         DIV_RESET   = 8'd20;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 18'd6554;
	localparam logic [7:0]         DM1_RESET   = 8'd19;

	// Register file: one register, byte address 4 * index.
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_FADE_DIVISOR = 1'b0;

	// Color modes.
	localparam logic [2:0] MODE_WARM       = 3'd0;
	localparam logic [2:0] MODE_WARM_PLUS  = 3'd1;
	localparam logic [2:0] MODE_BOTH       = 3'd2;
	localparam logic [2:0] MODE_WHITE_PLUS = 3'd3;
	localparam logic [2:0] MODE_WHITE      = 3'd4;
	localparam logic [2:0] MODE_FIRST      = MODE_WARM;
	localparam logic [2:0] MODE_LAST       = MODE_WHITE;
	localparam logic [2:0] MODE_RESET      = MODE_BOTH;

	// Factor bits: [1] warm full, [0] warm half, [3] white full, [2] white half.
	localparam logic [3:0] FB_WARM       = 4'b0010;
	localparam logic [3:0] FB_WARM_PLUS  = 4'b0110;
	localparam logic [3:0] FB_BOTH       = 4'b1010;
	localparam logic [3:0] FB_WHITE_PLUS = 4'b1001;
	localparam logic [3:0] FB_WHITE      = 4'b1000;

	typedef struct packed {
		logic [7:0] warm;
		logic [7:0] white;
	} goal_t;

	typedef struct packed {
		logic [RECIP_W-1:0] recip;
		logic [7:0]         dm1;
	} fade_cfg_t;

	function automatic logic [3:0] mode_bits(input logic [2:0] mode);
		logic [3:0] bits;
		unique case (mode)
			MODE_WARM:       bits = FB_WARM;
			MODE_WARM_PLUS:  bits = FB_WARM_PLUS;
			MODE_BOTH:       bits = FB_BOTH;
			MODE_WHITE_PLUS: bits = FB_WHITE_PLUS;
			MODE_WHITE:      bits = FB_WHITE;
			default:         bits = FB_WARM;
		endcase
		return bits;
	endfunction

endpackage

[src/tcld_cfg.sv]
module tcld_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcld_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output tcld_pkg::fade_cfg_t         fade_cfg,
	output logic                        busy
);
	import tcld_pkg::*;

	logic [7:0]             div_q;
	logic [7:0]             dsr_q;
	logic [RECIP_W-1:0]     num_q;
	logic [8:0]             rem_q;
	logic [RECIP_CNT_W-1:0] cnt_q;
	logic [RECIP_W-1:0]     recip_q;
	logic [7:0]             dm1_q;

	logic                   wr_en;
	logic [7:0]             d_eff;
	logic [8:0]             rem_sh;
	logic                   q_bit;
	logic [8:0]             rem_nx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_FADE_DIVISOR);
	assign d_eff  = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];

	// Restoring division of (2**17 + d - 1) by d, one quotient bit a cycle.
	assign rem_sh = {rem_q[7:0], num_q[RECIP_W-1]};
	assign q_bit  = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = q_bit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= DIV_RESET;
			recip_q <= RECIP_RESET;
			dm1_q   <= DM1_RESET;
			cnt_q   <= '0;
		end else if (wr_en) begin
			div_q <= pwdata[7:0];
			dm1_q <= d_eff - 8'd1;
			cnt_q <= RECIP_CNT_W'(RECIP_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == RECIP_CNT_W'(1))
				recip_q <= {num_q[RECIP_W-2:0], q_bit};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dsr_q <= d_eff;
			num_q <= (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(d_eff) - RECIP_W'(1);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[RECIP_W-2:0], q_bit};
			rem_q <= rem_nx;
		end
	end

	assign busy           = cnt_q != '0;
	assign fade_cfg.recip = recip_q;
	assign fade_cfg.dm1   = dm1_q;

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_FADE_DIVISOR)
			prdata = {24'd0, div_q};
	end

endmodule

[src/tcld_ctrl.sv]
module tcld_ctrl #(
	parameter int unsigned LEVEL_STEPS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                power_press,
	input  logic                color_press,
	input  logic                brightness_press,
	output tcld_pkg::goal_t     goals,
	output logic                lamp_next
);
	import tcld_pkg::*;

	localparam int unsigned LW   = $clog2(LEVEL_STEPS + 1);
	localparam logic [7:0]  STEP = 8'(255 / (LEVEL_STEPS + 1));

	logic          lamp_q;
	logic [2:0]    mode_q;
	logic [LW-1:0] lvl_q;

	logic [2:0]    mode_n;
	logic [LW-1:0] lvl_n;
	logic [11:0]   base_w;
	logic [7:0]    base;
	logic [3:0]    bits;

	function automatic logic [7:0] scale(input logic [7:0] b, input logic full,
			input logic half);
		logic [7:0] r;
		if (full)
			r = b;
		else if (half)
			r = b >> 1;
		else
			r = 8'd0;
		return r;
	endfunction

	// Power goes first, so color and brightness see the new on state.
	always_comb begin
		lamp_next = lamp_q ^ power_press;
		mode_n    = mode_q;
		lvl_n     = lvl_q;
		if (color_press && lamp_next)
			mode_n = (mode_q >= MODE_LAST) ? MODE_FIRST : mode_q + 3'd1;
		if (brightness_press && lamp_next)
			lvl_n = (lvl_q >= LW'(LEVEL_STEPS)) ? LW'(1) : lvl_q + LW'(1);
		base_w = {4'd0, STEP} * (12'(lvl_n) + 12'd1);
		base   = base_w[7:0];
		bits   = mode_bits(mode_n);
		goals.warm  = lamp_next ? scale(base, bits[1], bits[0]) : 8'd0;
		goals.white = lamp_next ? scale(base, bits[3], bits[2]) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q <= 1'b0;
			mode_q <= MODE_RESET;
			lvl_q  <= LW'(LEVEL_STEPS);
		end else if (en) begin
			lamp_q <= lamp_next;
			mode_q <= mode_n;
			lvl_q  <= lvl_n;
		end
	end

	`include "two_channel_lamp_dimmer_top_macros.svh"

	`TCLD_ASSERT(a_mode_range, mode_q <= MODE_LAST, "color mode left its cycle")
	`TCLD_ASSERT(a_lvl_range, (lvl_q != '0) && (lvl_q <= LW'(LEVEL_STEPS)), "level index out of range")
	`TCLD_ASSERT(a_off_dark, !lamp_next |-> (goals.warm == 8'd0) && (goals.white == 8'd0), "goal set while off")

endmodule

[src/tcld_fade.sv]
module tcld_fade (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          goal,
	input  tcld_pkg::fade_cfg_t fade_cfg,
	output logic [7:0]          level_next
);
	import tcld_pkg::*;

	logic [7:0]                 lvl_q;
	logic                       up;
	logic [8:0]                 num;
	logic [RECIP_W+8:0]         prod;
	logic [7:0]                 step;

	// Rising: ceil(diff / d) as floor((diff + d - 1) / d). Falling: truncate.
	// The reciprocal is exact for all numerators below 512.
	always_comb begin
		up   = goal > lvl_q;
		num  = up ? ({1'b0, goal - lvl_q} + {1'b0, fade_cfg.dm1}) : {1'b0, lvl_q - goal};
		prod = (RECIP_W+9)'(num) * (RECIP_W+9)'(fade_cfg.recip);
		step = prod[RECIP_SHIFT +: 8];
		level_next = up ? lvl_q + step : lvl_q - step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lvl_q <= 8'd0;
		else if (en)
			lvl_q <= level_next;
	end

endmodule

[src/two_channel_lamp_dimmer_top.sv]
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: power, color, brightness press
// m_        out  m_tvalid/m_tready  m_tdata: warm duty, white duty, lamp on
// apb       in   psel/penable       fade_divisor at byte address 0
//
// Three register stages: input, state update with fade, gamma lookup to output.
// One request per cycle unless busy or an m_tready stall holds s_tready low.
// A fade_divisor write starts the reciprocal division; s_tready is low until it ends.
// Reset (arst_n, async) gives lamp off, both mode, top level, levels zero.
// Stalls on m_tready back up through the stages; bubbles collapse.
module two_channel_lamp_dimmer_top #(
	parameter int unsigned LEVEL_STEPS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [0] power, [1] color, [2] brightness
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // [7:0] warm, [15:8] white, [16] lamp_on
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcld_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tcld_pkg::*;

	localparam logic [7:0] GAMMA [256] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
		8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,
		8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,
		8'd9,   8'd9,   8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
		8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,  8'd17,  8'd17,  8'd18,
		8'd18,  8'd19,  8'd19,  8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,
		8'd24,  8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,  8'd31,
		8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,  8'd39,
		8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,
		8'd50,  8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,
		8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd72,  8'd73,  8'd74,
		8'd75,  8'd77,  8'd78,  8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
		8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101, 8'd102, 8'd104, 8'd105,
		8'd107, 8'd109, 8'd110, 8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124,
		8'd126, 8'd127, 8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142, 8'd144,
		8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164, 8'd167,
		8'd169, 8'd171, 8'd173, 8'd175, 8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191,
		8'd193, 8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215, 8'd218,
		8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233, 8'd236, 8'd239, 8'd241, 8'd244, 8'd247,
		8'd249, 8'd252, 8'd255
	};

	fade_cfg_t  fade_cfg;
	goal_t      goals;
	logic       busy;
	logic       lamp_next;
	logic [7:0] warm_next;
	logic [7:0] white_next;

	logic       v_s1;
	logic       pwr_s1;
	logic       col_s1;
	logic       bri_s1;
	logic       v_s2;
	logic [7:0] warm_s2;
	logic [7:0] white_s2;
	logic       lamp_s2;
	logic       m_valid_q;
	logic [7:0] warm_duty_q;
	logic [7:0] white_duty_q;
	logic       lamp_on_q;

	logic       rdy_out;
	logic       rdy_s2;
	logic       rdy_s1;
	logic       adv_s1;

	assign rdy_out  = !m_valid_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign adv_s1   = v_s1 && rdy_s2;
	assign s_tready = rdy_s1 && !busy;

	tcld_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.fade_cfg (fade_cfg),
		.busy     (busy)
	);

	tcld_ctrl #(
		.LEVEL_STEPS (LEVEL_STEPS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (adv_s1),
		.power_press      (pwr_s1),
		.color_press      (col_s1),
		.brightness_press (bri_s1),
		.goals            (goals),
		.lamp_next        (lamp_next)
	);

	tcld_fade u_fade_warm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv_s1),
		.goal       (goals.warm),
		.fade_cfg   (fade_cfg),
		.level_next (warm_next)
	);

	tcld_fade u_fade_white (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv_s1),
		.goal       (goals.white),
		.fade_cfg   (fade_cfg),
		.level_next (white_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= s_tvalid && !busy;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_out)
				m_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pwr_s1 <= s_tdata[0];
			col_s1 <= s_tdata[1];
			bri_s1 <= s_tdata[2];
		end
		if (adv_s1) begin
			warm_s2  <= warm_next;
			white_s2 <= white_next;
			lamp_s2  <= lamp_next;
		end
		if (v_s2 && rdy_out) begin
			warm_duty_q  <= GAMMA[warm_s2];
			white_duty_q <= GAMMA[white_s2];
			lamp_on_q    <= lamp_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, lamp_on_q, white_duty_q, warm_duty_q};

	`include "two_channel_lamp_dimmer_top_macros.svh"

	`TCLD_NEVER(a_busy_block, busy && s_tready, "request taken during reciprocal update")
	`TCLD_ASSERT(a_s1_fill, s_tvalid && s_tready |=> v_s1, "accepted request lost at input stage")
	`TCLD_ASSERT(a_out_fill, v_s2 && rdy_out |=> m_tvalid, "result lost at output stage")

endmodule
